/* rtl/scirc_pkg.sv */
// Shared types and step counts for the segment/circle intersection pipeline.
// Used by segment_circle_intersection_top; no dependencies.
package scirc_pkg;

  // root bits of sqrt(len^2) (radicand < 2^66)
  localparam int LSQ_STEPS = 33;
  // quotient bits of all three rounding dividers (b, contact x and contact y)
  localparam int DIV_STEPS = 34;
  // root bits of sqrt(b*b - c) (radicand < 2^68)
  localparam int SSQ_STEPS = 34;

  // sideband that travels with each word; fields are filled as stages produce them
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [68:0] c;
    logic signed [66:0] p;
    logic        [32:0] len;
    logic signed [34:0] b;
    logic        [32:0] t;
    logic               zero;
    logic               miss;
  } item_t;

endpackage

/* rtl/segment_circle_intersection_top.sv */
// Segment versus circle intersection, fully pipelined, Q15.16 in and out.
// Throughput: one word per cycle; the whole pipe holds while a result is stalled.
// The pipe has one register stage per root bit of the two square roots and one per
// quotient bit of the two divider chains.
// Reset (rst, synchronous) clears all stage valid bits; payload is not reset.
module segment_circle_intersection_top
  import scirc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] circle_pos_x,
  input  logic signed [31:0] circle_pos_y,
  input  logic signed [31:0] circle_off_x,
  input  logic signed [31:0] circle_off_y,
  input  logic        [30:0] circle_rad,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- A: center, deltas ----------------
  logic               a_vld;
  item_t              a_it;
  logic signed [33:0] a_mx, a_my;
  logic signed [31:0] a_r;

  item_t              a_it_next;
  logic signed [32:0] cx, cy;
  logic signed [33:0] mx_next, my_next;

  always_comb begin
    cx = 33'(circle_pos_x) + 33'(circle_off_x);
    cy = 33'(circle_pos_y) + 33'(circle_off_y);
    mx_next = 34'(start_x) - 34'(cx);
    my_next = 34'(start_y) - 34'(cy);
    a_it_next = '0;
    a_it_next.sx = start_x;
    a_it_next.sy = start_y;
    a_it_next.dx = 33'(end_x) - 33'(start_x);
    a_it_next.dy = 33'(end_y) - 33'(start_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_it <= a_it_next;
      a_mx <= mx_next;
      a_my <= my_next;
      a_r  <= $signed({1'b0, circle_rad});
    end
  end

  // ---------------- B: products ----------------
  logic               b_vld;
  item_t              b_it;
  logic signed [67:0] b_mxx, b_myy;
  logic signed [65:0] b_dxx, b_dyy;
  logic signed [66:0] b_mdx, b_mdy;
  logic signed [62:0] b_rr;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_it  <= a_it;
      b_mxx <= a_mx * a_mx;
      b_myy <= a_my * a_my;
      b_dxx <= a_it.dx * a_it.dx;
      b_dyy <= a_it.dy * a_it.dy;
      b_mdx <= a_mx * a_it.dx;
      b_mdy <= a_my * a_it.dy;
      b_rr  <= a_r * a_r;
    end
  end

  // ---------------- C: sums, feeds length sqrt ----------------
  logic        lq_vld  [0:LSQ_STEPS];
  item_t       lq_it   [0:LSQ_STEPS];
  logic [65:0] lq_rad  [0:LSQ_STEPS];
  logic [34:0] lq_rem  [0:LSQ_STEPS];
  logic [32:0] lq_root [0:LSQ_STEPS];

  item_t c_it_next;

  always_comb begin
    c_it_next      = b_it;
    c_it_next.c    = 69'(b_mxx) + 69'(b_myy) - 69'(b_rr);
    c_it_next.p    = 67'(b_mdx) + 67'(b_mdy);
    c_it_next.zero = (b_dxx == '0) && (b_dyy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lq_vld[0] <= 1'b0;
    end else if (en) begin
      lq_vld[0] <= b_vld;
    end
    if (en) begin
      lq_it[0]   <= c_it_next;
      lq_rad[0]  <= 66'(b_dxx) + 66'(b_dyy);
      lq_rem[0]  <= '0;
      lq_root[0] <= '0;
    end
  end

  // one root bit per stage
  for (genvar i = 0; i < LSQ_STEPS; i++) begin : g_lsq
    logic [34:0] rem_sh, trial, rem_sub;
    logic        ge;
    assign rem_sh  = {lq_rem[i][32:0], lq_rad[i][65:64]};
    assign trial   = {lq_root[i], 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        lq_vld[i+1] <= 1'b0;
      end else if (en) begin
        lq_vld[i+1] <= lq_vld[i];
      end
      if (en) begin
        lq_it[i+1]   <= lq_it[i];
        lq_rad[i+1]  <= {lq_rad[i][63:0], 2'b00};
        lq_rem[i+1]  <= ge ? rem_sub : rem_sh;
        lq_root[i+1] <= {lq_root[i][31:0], ge};
      end
    end
  end

  // ---------------- D: round length ----------------
  logic  d_vld;
  item_t d_it;
  item_t d_it_next;

  always_comb begin
    d_it_next     = lq_it[LSQ_STEPS];
    d_it_next.len = lq_root[LSQ_STEPS] +
                    33'(lq_rem[LSQ_STEPS] > {2'b00, lq_root[LSQ_STEPS]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= lq_vld[LSQ_STEPS];
    end
    if (en) begin
      d_it <= d_it_next;
    end
  end

  // ---------------- E: b = p / len divider ----------------
  logic        bd_vld [0:DIV_STEPS];
  item_t       bd_it  [0:DIV_STEPS];
  logic [33:0] bd_num [0:DIV_STEPS];
  logic [33:0] bd_rem [0:DIV_STEPS];
  logic [33:0] bd_den [0:DIV_STEPS];
  logic [33:0] bd_q   [0:DIV_STEPS];

  logic [65:0] e_pmag;
  logic [67:0] e_num;

  always_comb begin
    e_pmag = d_it.p[66] ? 66'(-d_it.p) : 66'(d_it.p);
    e_num  = {1'b0, e_pmag, 1'b0} + 68'(d_it.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bd_vld[0] <= 1'b0;
    end else if (en) begin
      bd_vld[0] <= d_vld;
    end
    if (en) begin
      bd_it[0]  <= d_it;
      bd_rem[0] <= e_num[67:34];
      bd_num[0] <= e_num[33:0];
      bd_den[0] <= {d_it.len, 1'b0};
      bd_q[0]   <= '0;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_bdiv
    logic [34:0] rem_sh, rem_sub;
    logic        ge;
    assign rem_sh  = {bd_rem[i], bd_num[i][33]};
    assign ge      = rem_sh >= {1'b0, bd_den[i]};
    assign rem_sub = rem_sh - {1'b0, bd_den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        bd_vld[i+1] <= 1'b0;
      end else if (en) begin
        bd_vld[i+1] <= bd_vld[i];
      end
      if (en) begin
        bd_it[i+1]  <= bd_it[i];
        bd_rem[i+1] <= ge ? rem_sub[33:0] : rem_sh[33:0];
        bd_num[i+1] <= {bd_num[i][32:0], 1'b0};
        bd_den[i+1] <= bd_den[i];
        bd_q[i+1]   <= {bd_q[i][32:0], ge};
      end
    end
  end

  // ---------------- F: signed b, early miss ----------------
  logic  f_vld;
  item_t f_it;
  item_t f_it_next;
  logic signed [34:0] f_bq;

  always_comb begin
    f_bq      = $signed({1'b0, bd_q[DIV_STEPS]});
    f_it_next = bd_it[DIV_STEPS];
    f_it_next.b = f_it_next.p[66] ? -f_bq : f_bq;
    // start outside and segment pointing away
    f_it_next.miss = (f_it_next.c > 0) && (f_it_next.b > 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= bd_vld[DIV_STEPS];
    end
    if (en) begin
      f_it <= f_it_next;
    end
  end

  // ---------------- G: b*b ----------------
  logic               g_vld;
  item_t              g_it;
  logic signed [69:0] g_bb;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
    if (en) begin
      g_it <= f_it;
      g_bb <= f_it.b * f_it.b;
    end
  end

  // ---------------- H: discriminant, feeds second sqrt ----------------
  logic        sq_vld  [0:SSQ_STEPS];
  item_t       sq_it   [0:SSQ_STEPS];
  logic [67:0] sq_rad  [0:SSQ_STEPS];
  logic [35:0] sq_rem  [0:SSQ_STEPS];
  logic [33:0] sq_root [0:SSQ_STEPS];

  logic signed [70:0] h_disc;
  item_t              h_it_next;

  always_comb begin
    h_disc    = 71'(g_bb) - 71'(g_it.c);
    h_it_next = g_it;
    h_it_next.miss = g_it.miss || h_disc[70];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= g_vld;
    end
    if (en) begin
      sq_it[0]   <= h_it_next;
      sq_rad[0]  <= h_disc[67:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar i = 0; i < SSQ_STEPS; i++) begin : g_ssq
    logic [35:0] rem_sh, trial, rem_sub;
    logic        ge;
    assign rem_sh  = {sq_rem[i][33:0], sq_rad[i][67:66]};
    assign trial   = {sq_root[i], 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else if (en) begin
        sq_vld[i+1] <= sq_vld[i];
      end
      if (en) begin
        sq_it[i+1]   <= sq_it[i];
        sq_rad[i+1]  <= {sq_rad[i][65:0], 2'b00};
        sq_rem[i+1]  <= ge ? rem_sub : rem_sh;
        sq_root[i+1] <= {sq_root[i][32:0], ge};
      end
    end
  end

  // ---------------- I: round s ----------------
  logic        i_vld;
  item_t       i_it;
  logic [34:0] i_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (en) begin
      i_vld <= sq_vld[SSQ_STEPS];
    end
    if (en) begin
      i_it <= sq_it[SSQ_STEPS];
      i_s  <= {1'b0, sq_root[SSQ_STEPS]} +
              35'(sq_rem[SSQ_STEPS] > {2'b00, sq_root[SSQ_STEPS]});
    end
  end

  // ---------------- J: t = -b - s, clamp ----------------
  logic               j_vld;
  item_t              j_it;
  item_t              j_it_next;
  logic signed [35:0] j_t;

  always_comb begin
    j_t       = -36'(i_it.b) - $signed({1'b0, i_s});
    j_it_next = i_it;
    j_it_next.miss = i_it.miss || (j_t > $signed({3'b000, i_it.len}));
    j_it_next.t    = j_t[35] ? '0 : j_t[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (en) begin
      j_vld <= i_vld;
    end
    if (en) begin
      j_it <= j_it_next;
    end
  end

  // ---------------- K: t*|d| ----------------
  logic        k_vld;
  item_t       k_it;
  logic [65:0] k_px, k_py;
  logic [32:0] k_adx, k_ady;

  always_comb begin
    k_adx = j_it.dx[32] ? 33'(-j_it.dx) : 33'(j_it.dx);
    k_ady = j_it.dy[32] ? 33'(-j_it.dy) : 33'(j_it.dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (en) begin
      k_vld <= j_vld;
    end
    if (en) begin
      k_it <= j_it;
      k_px <= j_it.t * k_adx;
      k_py <= j_it.t * k_ady;
    end
  end

  // ---------------- L: contact offset dividers ----------------
  logic        qd_vld  [0:DIV_STEPS];
  item_t       qd_it   [0:DIV_STEPS];
  logic [33:0] qd_den  [0:DIV_STEPS];
  logic [33:0] qd_numx [0:DIV_STEPS];
  logic [33:0] qd_numy [0:DIV_STEPS];
  logic [33:0] qd_remx [0:DIV_STEPS];
  logic [33:0] qd_remy [0:DIV_STEPS];
  logic [33:0] qd_qx   [0:DIV_STEPS];
  logic [33:0] qd_qy   [0:DIV_STEPS];

  logic [67:0] l_numx, l_numy;

  always_comb begin
    l_numx = {1'b0, k_px, 1'b0} + 68'(k_it.len);
    l_numy = {1'b0, k_py, 1'b0} + 68'(k_it.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qd_vld[0] <= 1'b0;
    end else if (en) begin
      qd_vld[0] <= k_vld;
    end
    if (en) begin
      qd_it[0]   <= k_it;
      qd_den[0]  <= {k_it.len, 1'b0};
      qd_remx[0] <= l_numx[67:34];
      qd_numx[0] <= l_numx[33:0];
      qd_remy[0] <= l_numy[67:34];
      qd_numy[0] <= l_numy[33:0];
      qd_qx[0]   <= '0;
      qd_qy[0]   <= '0;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_qdiv
    logic [34:0] shx, shy, subx, suby;
    logic        gex, gey;
    assign shx  = {qd_remx[i], qd_numx[i][33]};
    assign shy  = {qd_remy[i], qd_numy[i][33]};
    assign gex  = shx >= {1'b0, qd_den[i]};
    assign gey  = shy >= {1'b0, qd_den[i]};
    assign subx = shx - {1'b0, qd_den[i]};
    assign suby = shy - {1'b0, qd_den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        qd_vld[i+1] <= 1'b0;
      end else if (en) begin
        qd_vld[i+1] <= qd_vld[i];
      end
      if (en) begin
        qd_it[i+1]   <= qd_it[i];
        qd_den[i+1]  <= qd_den[i];
        qd_remx[i+1] <= gex ? subx[33:0] : shx[33:0];
        qd_remy[i+1] <= gey ? suby[33:0] : shy[33:0];
        qd_numx[i+1] <= {qd_numx[i][32:0], 1'b0};
        qd_numy[i+1] <= {qd_numy[i][32:0], 1'b0};
        qd_qx[i+1]   <= {qd_qx[i][32:0], gex};
        qd_qy[i+1]   <= {qd_qy[i][32:0], gey};
      end
    end
  end

  // ---------------- M: output word ----------------
  item_t       m_it;
  logic [31:0] m_qx, m_qy;
  logic        m_hit;
  logic [31:0] m_hx, m_hy;

  always_comb begin
    m_it = qd_it[DIV_STEPS];
    m_qx = qd_qx[DIV_STEPS][31:0];
    m_qy = qd_qy[DIV_STEPS][31:0];
    if (m_it.zero) begin
      // degenerate segment: hit only when the start is inside or on the circle
      m_hit = (m_it.c <= 0);
      m_hx  = m_it.sx;
      m_hy  = m_it.sy;
    end else begin
      m_hit = !m_it.miss;
      m_hx  = m_it.sx + (m_it.dx[32] ? -m_qx : m_qx);
      m_hy  = m_it.sy + (m_it.dy[32] ? -m_qy : m_qy);
    end
    if (!m_hit) begin
      m_hx = '0;
      m_hy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= qd_vld[DIV_STEPS];
    end
    if (en) begin
      hit   <= m_hit;
      hit_x <= m_hx;
      hit_y <= m_hy;
    end
  end

`ifndef SYNTH
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_word_moves: assert property (@(posedge clk) disable iff (rst)
    en && f_vld |=> g_vld)
    else $error("word lost between b and b*b stages");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    d_vld && d_it.zero |-> d_it.len == '0)
    else $error("zero-length segment gave nonzero length");
`endif

endmodule

/* dv/tb_segment_circle_intersection_top.sv */
// Testbench for segment_circle_intersection_top: directed and random geometry words,
// checked against a bit-exact integer model of the intersection math.
// Depends on rtl/scirc_pkg.sv and rtl/segment_circle_intersection_top.sv.
`timescale 1ns / 1ps

module tb_segment_circle_intersection_top;
  import scirc_pkg::*;

  localparam int LATENCY = 148;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] px, py, ox, oy;
    logic [30:0] rad;
    logic signed [31:0] sx, sy, ex, ey;
  } query_t;

  typedef struct {
    logic hit;
    logic signed [31:0] x, y;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] circle_pos_x = '0, circle_pos_y = '0;
  logic signed [31:0] circle_off_x = '0, circle_off_y = '0;
  logic [30:0] circle_rad = '0;
  logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic signed [31:0] hit_x, hit_y;

  contact_t contact_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit rx_random = 1'b1;

  segment_circle_intersection_top i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // floor sqrt then round to nearest
  function automatic logic [35:0] sqrt_round(logic [71:0] n);
    logic [35:0] y;
    logic [35:0] c;
    y = '0;
    for (int k = 35; k >= 0; k--) begin
      c = y | (36'd1 << k);
      if (72'(c) * 72'(c) <= n) y = c;
    end
    if (n > 72'(y) * 72'(y) + 72'(y)) y = y + 1;
    return y;
  endfunction

  // n/d rounded to nearest, ties up (magnitudes)
  function automatic logic [71:0] div_round(logic [71:0] n, logic [71:0] d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic contact_t first_contact(query_t q);
    logic signed [71:0] cx, cy, r, sx, sy, dx, dy, mx, my, c, p, b, disc, t, qx, qy;
    logic [71:0] len2, len, bq;
    contact_t res;
    cx = 72'(q.px) + 72'(q.ox);
    cy = 72'(q.py) + 72'(q.oy);
    r = 72'(q.rad);
    sx = 72'(q.sx);
    sy = 72'(q.sy);
    dx = 72'(q.ex) - sx;
    dy = 72'(q.ey) - sy;
    mx = sx - cx;
    my = sy - cy;
    len2 = dx * dx + dy * dy;
    c = mx * mx + my * my - r * r;
    res = '{1'b0, '0, '0};
    if (len2 == 0) begin
      if (c <= 0) res = '{1'b1, q.sx, q.sy};
      return res;
    end
    len = sqrt_round(len2);
    p = mx * dx + my * dy;
    bq = div_round(p < 0 ? -p : p, len);
    b = p < 0 ? -$signed(bq) : $signed(bq);
    if (c > 0 && b > 0) return res;
    disc = b * b - c;
    if (disc < 0) return res;
    t = -b - $signed(72'(sqrt_round(disc)));
    if (t > $signed(len)) return res;
    if (t < 0) t = 0;
    qx = div_round(t * (dx < 0 ? -dx : dx), len);
    qy = div_round(t * (dy < 0 ? -dy : dy), len);
    res.hit = 1'b1;
    res.x = 32'(sx + (dx < 0 ? -qx : qx));
    res.y = 32'(sy + (dy < 0 ? -qy : qy));
    return res;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // leaves valid high on return so the next word can follow with no gap
  task automatic send_word(query_t q, int gap = -1);
    int idle;
    idle = (gap < 0) ? $urandom_range(0, 7) : gap;
    if ($urandom_range(0, 3) == 0) idle = 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    circle_pos_x <= q.px; circle_pos_y <= q.py;
    circle_off_x <= q.ox; circle_off_y <= q.oy;
    circle_rad <= q.rad;
    start_x <= q.sx; start_y <= q.sy; end_x <= q.ex; end_y <= q.ey;
    in_valid <= 1'b1;
    contact_q.push_back(first_contact(q));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (rx_random) begin
        n = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) n = 0;
        out_stall <= (n != 0);
        repeat (n) @(negedge clk);
        if (n != 0 && !hold_off) out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    contact_t want;
    if (!rst && out_valid && !out_stall) begin
      if (contact_q.size() == 0) begin
        report("unexpected word", hit_x, '0);
      end else begin
        want = contact_q.pop_front();
        if (hit !== want.hit) report("hit", 32'(hit), 32'(want.hit));
        if (hit_x !== want.x) report("hit_x", hit_x, want.x);
        if (hit_y !== want.y) report("hit_y", hit_y, want.y);
      end
    end
  end

  function automatic logic signed [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int sc;
    if ($urandom_range(0, 4) == 0) begin
      q = '{rnd32(), rnd32(), rnd32(), rnd32(), 31'($urandom), rnd32(), rnd32(),
            rnd32(), rnd32()};
      return q;
    end
    // local geometry at a random scale so hits and misses both occur
    sc = $urandom_range(4, 26);
    q.px = $signed($urandom) >>> (31 - sc);
    q.py = $signed($urandom) >>> (31 - sc);
    q.ox = $signed($urandom) >>> (31 - sc);
    q.oy = $signed($urandom) >>> (31 - sc);
    q.rad = 31'($urandom_range(0, 32'd1 << (sc + 1)));
    q.sx = q.px + q.ox + ($signed($urandom) >>> (30 - sc));
    q.sy = q.py + q.oy + ($signed($urandom) >>> (30 - sc));
    if ($urandom_range(0, 15) == 0) begin
      q.ex = q.sx; q.ey = q.sy;
    end else begin
      q.ex = q.px + q.ox + ($signed($urandom) >>> (30 - sc));
      q.ey = q.py + q.oy + ($signed($urandom) >>> (30 - sc));
    end
    return q;
  endfunction

  task automatic test_directed();
    query_t q;
    localparam logic signed [31:0] MX = 32'sh7fffffff, MN = 32'sh80000000;
    localparam logic signed [31:0] ONE = 32'sh00010000;
    // crossing through center, start outside
    send_word('{'0, '0, '0, '0, 31'(ONE), -3 * ONE, '0, 3 * ONE, '0});
    // start inside: clamps to start
    send_word('{'0, '0, '0, '0, 31'(2 * ONE), ONE / 2, ONE / 4, 3 * ONE, ONE});
    // start on boundary
    send_word('{'0, '0, '0, '0, 31'(ONE), ONE, '0, 4 * ONE, '0});
    // pointing away from circle
    send_word('{'0, '0, '0, '0, 31'(ONE), 2 * ONE, '0, 5 * ONE, '0});
    // line misses circle
    send_word('{'0, '0, '0, '0, 31'(ONE), -3 * ONE, 2 * ONE, 3 * ONE, 2 * ONE});
    // segment stops short
    send_word('{'0, '0, '0, '0, 31'(ONE), -5 * ONE, '0, -2 * ONE, '0});
    // tangent
    send_word('{'0, '0, '0, '0, 31'(ONE), -3 * ONE, ONE, 3 * ONE, ONE});
    // zero length inside, on, outside
    send_word('{ONE, ONE, '0, '0, 31'(ONE), ONE, ONE, ONE, ONE});
    send_word('{'0, '0, '0, '0, 31'(ONE), ONE, '0, ONE, '0});
    send_word('{'0, '0, '0, '0, 31'(ONE), 5 * ONE, '0, 5 * ONE, '0});
    // zero radius
    send_word('{'0, '0, '0, '0, '0, -ONE, '0, ONE, '0});
    // field extremes
    send_word('{MX, MX, MX, MX, 31'h7fffffff, MN, MN, MX, MX});
    send_word('{MN, MN, MN, MN, 31'h7fffffff, MX, MX, MN, MN});
    send_word('{MX, MN, MN, MX, 31'h7fffffff, MN, MX, MX, MN});
    send_word('{MN, MX, MX, MN, '0, MX, MN, MN, MX});
    send_word('{'0, '0, '0, '0, 31'h7fffffff, MN, MN, MN, MN});
    send_word('{-1, -1, -1, -1, 31'h55555555, -1, -1, '0, '0});
    send_word('{MX, '0, MX, '0, 31'h2aaaaaaa, MX, '0, MN, '0});
    q = '{'0, '0, '0, '0, 31'(ONE), '0, -3 * ONE, '0, 3 * ONE};
    send_word(q);
  endtask

  task automatic test_random(int n);
    repeat (n) send_word(rnd_query());
  endtask

  task automatic test_backpressure();
    int hold;
    hold = 400;
    fork
      begin
        hold_off = 1'b1;
        repeat (hold) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (200) send_word(rnd_query(), 0);
        release_input();
      end
    join
  endtask

  task automatic test_drain_pause();
    wait (contact_q.size() == 0);
    repeat (10) @(negedge clk);
    test_random(20);
  endtask

  task automatic test_full_rate();
    rx_random = 1'b0;
    repeat (100) send_word(rnd_query(), 0);
    rx_random = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300);
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    test_random(80);
    release_input();
    wait (contact_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && contact_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* segment_circle_intersection_top.f */
rtl/scirc_pkg.sv
rtl/segment_circle_intersection_top.sv
dv/tb_segment_circle_intersection_top.sv
